[hw/rtl/multilevel_round_robin_scheduler_assert.svh]
// Assertion macros for the multilevel round-robin scheduler.
// No dependencies; included by files that carry concurrent checks.
`ifndef MULTILEVEL_ROUND_ROBIN_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_ROUND_ROBIN_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define MRRS_ASSERT_HOLD(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mrrs check failed");

// next-cycle implication
`define MRRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mrrs check failed");

`endif

[hw/rtl/mrrs_pkg.sv]
// Shared types and constants for the multilevel round-robin scheduler.
// No dependencies.
package mrrs_pkg;

    localparam int DEF_NUM_TASKS  = 64;
    localparam int DEF_NUM_LEVELS = 8;

    localparam logic [7:0] INIT_SLICE_T0 = 8'd2;
    localparam logic [7:0] INIT_SLICE_T1 = 8'd1;

    typedef enum logic [1:0] {
        MARK_FREE  = 2'd0,
        MARK_SLEEP = 2'd1,
        MARK_RUN   = 2'd2
    } mark_t;

    typedef enum logic [1:0] {
        FN_ALLOC = 2'd0,
        FN_RUN   = 2'd1,
        FN_SLEEP = 2'd2,
        FN_TICK  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STS_DONE    = 2'd0,
        STS_NO_FREE = 2'd1,
        STS_NOT_RUN = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DISP, S_AL_RD, S_AL_CHK, S_TT_RD, S_RUN_EV, S_SL_EV,
        S_BF_LV, S_BF_L, S_BF_T, S_RM_LV, S_RM_RD, S_RM_CHK, S_SH_RD, S_SH_WR,
        S_RM_RET, S_ADD_LV, S_ADD, S_RUN_WR, S_SL_WR, S_TK_ADV, S_PICK_INIT,
        S_PICK, S_FIN_LV, S_FIN_L, S_FIN_T, S_FIN_OUT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLR, OP_LOAD, OP_TRD_IDX, OP_AL_CHK, OP_TRD_TID, OP_RUN_EV,
        OP_SL_EV, OP_LV_CUR, OP_LRD_CUR, OP_BF_CAP, OP_LV_TASK, OP_LRD_IDX,
        OP_RM_CHK, OP_LRD_IDX1, OP_SH_WR, OP_LV_NEW, OP_ADD, OP_RUN_WR,
        OP_SL_WR, OP_TK_ADV, OP_PICK_INIT, OP_PICK, OP_TRD_CUR, OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        func_t func;
        logic  oor;
        logic  t_free;
        logic  t_run;
        logic  lv_differs;
        logic  idx_ge_cnt;
        logic  idx_last;
        logic  match;
        logic  tid_is_before;
        logic  cnt_nz;
        logic  lv_last;
        logic  pending;
    } dp_stat_t;

endpackage

[hw/rtl/mrrs_ctrl.sv]
// Sequencer for the scheduler: walks each command through datapath steps.
// Depends on mrrs_pkg.
module mrrs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output mrrs_pkg::dp_cmd_t  cmd,
    input  mrrs_pkg::dp_stat_t stat
);

    mrrs_pkg::state_t state_reg;
    mrrs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mrrs_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = mrrs_pkg::OP_NONE;
        busy       = (state_reg != mrrs_pkg::S_IDLE);
        case (state_reg)
            mrrs_pkg::S_CLEAR:
            begin
                cmd.op = mrrs_pkg::OP_CLR;
                if (stat.idx_last)
                begin
                    state_next = mrrs_pkg::S_IDLE;
                end
            end
            mrrs_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = mrrs_pkg::OP_LOAD;
                    state_next = mrrs_pkg::S_DISP;
                end
            end
            mrrs_pkg::S_DISP:
            begin
                case (stat.func)
                    mrrs_pkg::FN_ALLOC: state_next = mrrs_pkg::S_AL_RD;
                    mrrs_pkg::FN_TICK:  state_next = mrrs_pkg::S_BF_LV;
                    default:
                    begin
                        state_next = stat.oor ? mrrs_pkg::S_FIN_LV : mrrs_pkg::S_TT_RD;
                    end
                endcase
            end
            mrrs_pkg::S_AL_RD:
            begin
                cmd.op     = mrrs_pkg::OP_TRD_IDX;
                state_next = mrrs_pkg::S_AL_CHK;
            end
            mrrs_pkg::S_AL_CHK:
            begin
                cmd.op     = mrrs_pkg::OP_AL_CHK;
                state_next = (stat.t_free || stat.idx_last) ? mrrs_pkg::S_FIN_LV
                                                            : mrrs_pkg::S_AL_RD;
            end
            mrrs_pkg::S_TT_RD:
            begin
                cmd.op     = mrrs_pkg::OP_TRD_TID;
                state_next = (stat.func == mrrs_pkg::FN_RUN) ? mrrs_pkg::S_RUN_EV
                                                             : mrrs_pkg::S_SL_EV;
            end
            mrrs_pkg::S_RUN_EV:
            begin
                cmd.op = mrrs_pkg::OP_RUN_EV;
                if (stat.t_run && stat.lv_differs)
                begin
                    state_next = mrrs_pkg::S_RM_LV;
                end
                else if (!stat.t_run)
                begin
                    state_next = mrrs_pkg::S_ADD_LV;
                end
                else
                begin
                    state_next = mrrs_pkg::S_RUN_WR;
                end
            end
            mrrs_pkg::S_SL_EV:
            begin
                cmd.op     = mrrs_pkg::OP_SL_EV;
                state_next = stat.t_run ? mrrs_pkg::S_BF_LV : mrrs_pkg::S_FIN_LV;
            end
            mrrs_pkg::S_BF_LV:
            begin
                cmd.op     = mrrs_pkg::OP_LV_CUR;
                state_next = mrrs_pkg::S_BF_L;
            end
            mrrs_pkg::S_BF_L:
            begin
                cmd.op     = mrrs_pkg::OP_LRD_CUR;
                state_next = mrrs_pkg::S_BF_T;
            end
            mrrs_pkg::S_BF_T:
            begin
                cmd.op     = mrrs_pkg::OP_BF_CAP;
                state_next = (stat.func == mrrs_pkg::FN_TICK) ? mrrs_pkg::S_TK_ADV
                                                              : mrrs_pkg::S_RM_LV;
            end
            mrrs_pkg::S_RM_LV:
            begin
                cmd.op     = mrrs_pkg::OP_LV_TASK;
                state_next = mrrs_pkg::S_RM_RD;
            end
            mrrs_pkg::S_RM_RD:
            begin
                cmd.op     = mrrs_pkg::OP_LRD_IDX;
                state_next = stat.idx_ge_cnt ? mrrs_pkg::S_RM_RET : mrrs_pkg::S_RM_CHK;
            end
            mrrs_pkg::S_RM_CHK:
            begin
                cmd.op     = mrrs_pkg::OP_RM_CHK;
                state_next = stat.match ? mrrs_pkg::S_SH_RD : mrrs_pkg::S_RM_RD;
            end
            mrrs_pkg::S_SH_RD:
            begin
                cmd.op     = mrrs_pkg::OP_LRD_IDX1;
                state_next = stat.idx_ge_cnt ? mrrs_pkg::S_RM_RET : mrrs_pkg::S_SH_WR;
            end
            mrrs_pkg::S_SH_WR:
            begin
                cmd.op     = mrrs_pkg::OP_SH_WR;
                state_next = mrrs_pkg::S_SH_RD;
            end
            mrrs_pkg::S_RM_RET:
            begin
                state_next = (stat.func == mrrs_pkg::FN_RUN) ? mrrs_pkg::S_ADD_LV
                                                             : mrrs_pkg::S_SL_WR;
            end
            mrrs_pkg::S_ADD_LV:
            begin
                cmd.op     = mrrs_pkg::OP_LV_NEW;
                state_next = mrrs_pkg::S_ADD;
            end
            mrrs_pkg::S_ADD:
            begin
                cmd.op     = mrrs_pkg::OP_ADD;
                state_next = mrrs_pkg::S_RUN_WR;
            end
            mrrs_pkg::S_RUN_WR:
            begin
                cmd.op     = mrrs_pkg::OP_RUN_WR;
                state_next = mrrs_pkg::S_FIN_LV;
            end
            mrrs_pkg::S_SL_WR:
            begin
                cmd.op     = mrrs_pkg::OP_SL_WR;
                state_next = stat.tid_is_before ? mrrs_pkg::S_PICK_INIT
                                                : mrrs_pkg::S_FIN_LV;
            end
            mrrs_pkg::S_TK_ADV:
            begin
                cmd.op     = mrrs_pkg::OP_TK_ADV;
                state_next = stat.pending ? mrrs_pkg::S_PICK_INIT : mrrs_pkg::S_FIN_LV;
            end
            mrrs_pkg::S_PICK_INIT:
            begin
                cmd.op     = mrrs_pkg::OP_PICK_INIT;
                state_next = mrrs_pkg::S_PICK;
            end
            mrrs_pkg::S_PICK:
            begin
                cmd.op     = mrrs_pkg::OP_PICK;
                state_next = (stat.cnt_nz || stat.lv_last) ? mrrs_pkg::S_FIN_LV
                                                           : mrrs_pkg::S_PICK;
            end
            mrrs_pkg::S_FIN_LV:
            begin
                cmd.op     = mrrs_pkg::OP_LV_CUR;
                state_next = mrrs_pkg::S_FIN_L;
            end
            mrrs_pkg::S_FIN_L:
            begin
                cmd.op     = mrrs_pkg::OP_LRD_CUR;
                state_next = mrrs_pkg::S_FIN_T;
            end
            mrrs_pkg::S_FIN_T:
            begin
                cmd.op     = mrrs_pkg::OP_TRD_CUR;
                state_next = mrrs_pkg::S_FIN_OUT;
            end
            mrrs_pkg::S_FIN_OUT:
            begin
                cmd.op     = mrrs_pkg::OP_OUT;
                state_next = mrrs_pkg::S_IDLE;
            end
            default:
            begin
                state_next = mrrs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/mrrs_dp.sv]
// Scheduler datapath: task table, level lists, per-level count and cursor.
// Depends on mrrs_pkg; driven by mrrs_ctrl commands.
module mrrs_dp #(
    parameter int NUM_TASKS  = mrrs_pkg::DEF_NUM_TASKS,
    parameter int NUM_LEVELS = mrrs_pkg::DEF_NUM_LEVELS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mrrs_pkg::dp_cmd_t  cmd,
    output mrrs_pkg::dp_stat_t stat,
    input  logic [1:0]         func,
    input  logic [5:0]         task_id,
    input  logic signed [3:0]  target_level,
    input  logic [7:0]         slice_ticks,
    output logic               done,
    output logic [1:0]         status,
    output logic [5:0]         result_task,
    output logic [7:0]         reload_ticks,
    output logic               reload_timer,
    output logic               switch_needed
);

    localparam int TW  = $clog2(NUM_TASKS);
    localparam int IW  = TW + 1;
    localparam int LW  = $clog2(NUM_LEVELS);
    localparam int CW  = $clog2(NUM_TASKS + 1);
    localparam int LAW = $clog2(NUM_LEVELS * NUM_TASKS);

    // task table, three fields side by side
    mrrs_pkg::mark_t   mark_mem [NUM_TASKS];
    logic [LW-1:0]     lvl_mem  [NUM_TASKS];
    logic [7:0]        slc_mem  [NUM_TASKS];
    // per-level ordered lists, row per level
    logic [TW-1:0]     list_mem [NUM_LEVELS * NUM_TASKS];

    logic [CW-1:0]     cnt_reg  [NUM_LEVELS];
    logic [TW-1:0]     cur_reg  [NUM_LEVELS];

    logic [LW-1:0]     cur_level_reg;
    logic              pending_reg;
    logic [IW-1:0]     idx_reg;
    logic [LW-1:0]     lv_reg;
    logic              done_reg;

    mrrs_pkg::func_t   func_reg;
    mrrs_pkg::status_t status_reg;
    logic [TW-1:0]     tid_reg;
    logic              oor_reg;
    logic [3:0]        lvreq_reg;
    logic [7:0]        slc_in_reg;
    logic [TW-1:0]     res_reg;
    logic [TW-1:0]     before_reg;
    logic              sw_chk_reg;
    logic              reload_reg;
    logic [LW-1:0]     tlv_reg;
    logic [7:0]        tsl_reg;
    logic [LW-1:0]     newlv_reg;
    logic [7:0]        newslc_reg;

    mrrs_pkg::mark_t   tmark_q;
    logic [LW-1:0]     tlvl_q;
    logic [7:0]        tslc_q;
    logic [TW-1:0]     ldata_q;

    logic [1:0]        status_out_reg;
    logic [5:0]        result_out_reg;
    logic [7:0]        reload_out_reg;
    logic              timer_out_reg;
    logic              sw_out_reg;

    logic [CW-1:0]     cnt_rd;
    logic [TW-1:0]     cur_rd;
    logic [LW-1:0]     lv_new;
    logic [IW-1:0]     rd_off;
    logic [LAW-1:0]    la_rd;
    logic              l_rd_en;
    logic              lw_en;
    logic [LAW-1:0]    lw_addr;
    logic [TW-1:0]     lw_data;
    logic [TW-1:0]     t_rd_addr;
    logic              t_rd_en;
    logic              tw_en;
    logic [TW-1:0]     tw_addr;
    mrrs_pkg::mark_t   tw_mark;
    logic [LW-1:0]     tw_lvl;
    logic [7:0]        tw_slc;
    logic [CW-1:0]     n_new;
    logic [TW-1:0]     cur_dec;
    logic [TW-1:0]     cur_rm;
    logic [IW-1:0]     tick_nxt;
    logic              idx_last;

    assign cnt_rd   = cnt_reg[lv_reg];
    assign cur_rd   = cur_reg[lv_reg];
    assign idx_last = (idx_reg == IW'(NUM_TASKS - 1));

    // level requested by a run command, saturated; negative keeps the present level
    always_comb
    begin
        if (lvreq_reg[3])
        begin
            lv_new = tlvl_q;
        end
        else if (int'(lvreq_reg[2:0]) >= NUM_LEVELS)
        begin
            lv_new = LW'(NUM_LEVELS - 1);
        end
        else
        begin
            lv_new = LW'(lvreq_reg[2:0]);
        end
    end

    // removal bookkeeping
    assign n_new    = cnt_rd - CW'(1);
    assign cur_dec  = (idx_reg < IW'(cur_rd)) ? (cur_rd - TW'(1)) : cur_rd;
    assign cur_rm   = (CW'(cur_dec) >= n_new) ? '0 : cur_dec;
    assign tick_nxt = IW'(cur_rd) + IW'(1);

    // list read port
    always_comb
    begin
        case (cmd.op)
            mrrs_pkg::OP_LRD_CUR:  rd_off = IW'(cur_rd);
            mrrs_pkg::OP_LRD_IDX1: rd_off = idx_reg + IW'(1);
            default:               rd_off = idx_reg;
        endcase
        la_rd   = LAW'(lv_reg) * LAW'(NUM_TASKS) + LAW'(rd_off);
        l_rd_en = (cmd.op == mrrs_pkg::OP_LRD_CUR) || (cmd.op == mrrs_pkg::OP_LRD_IDX)
               || (cmd.op == mrrs_pkg::OP_LRD_IDX1);
    end

    // list write port
    always_comb
    begin
        lw_en   = 1'b0;
        lw_addr = la_rd;
        lw_data = ldata_q;
        case (cmd.op)
            mrrs_pkg::OP_CLR:
            begin
                if (idx_reg == IW'(0))
                begin
                    lw_en   = 1'b1;
                    lw_addr = '0;
                    lw_data = '0;
                end
                else if (idx_reg == IW'(1))
                begin
                    lw_en   = 1'b1;
                    lw_addr = LAW'((NUM_LEVELS - 1) * NUM_TASKS);
                    lw_data = TW'(1);
                end
            end
            mrrs_pkg::OP_ADD:
            begin
                lw_en   = (cnt_rd < CW'(NUM_TASKS));
                lw_addr = LAW'(lv_reg) * LAW'(NUM_TASKS) + LAW'(cnt_rd);
                lw_data = tid_reg;
            end
            mrrs_pkg::OP_SH_WR:
            begin
                lw_en   = 1'b1;
                lw_addr = LAW'(lv_reg) * LAW'(NUM_TASKS) + LAW'(idx_reg);
                lw_data = ldata_q;
            end
            default:
            begin
                lw_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (lw_en)
        begin
            list_mem[lw_addr] <= lw_data;
        end
        if (l_rd_en)
        begin
            ldata_q <= list_mem[la_rd];
        end
    end

    // task table ports
    always_comb
    begin
        case (cmd.op)
            mrrs_pkg::OP_TRD_TID: t_rd_addr = tid_reg;
            mrrs_pkg::OP_TRD_CUR: t_rd_addr = ldata_q;
            default:              t_rd_addr = idx_reg[TW-1:0];
        endcase
        t_rd_en = (cmd.op == mrrs_pkg::OP_TRD_TID) || (cmd.op == mrrs_pkg::OP_TRD_CUR)
               || (cmd.op == mrrs_pkg::OP_TRD_IDX);
        tw_en   = 1'b0;
        tw_addr = idx_reg[TW-1:0];
        tw_mark = mrrs_pkg::MARK_FREE;
        tw_lvl  = '0;
        tw_slc  = '0;
        case (cmd.op)
            mrrs_pkg::OP_CLR:
            begin
                tw_en = 1'b1;
                if (idx_reg == IW'(0))
                begin
                    tw_mark = mrrs_pkg::MARK_RUN;
                    tw_slc  = mrrs_pkg::INIT_SLICE_T0;
                end
                else if (idx_reg == IW'(1))
                begin
                    tw_mark = mrrs_pkg::MARK_RUN;
                    tw_lvl  = LW'(NUM_LEVELS - 1);
                    tw_slc  = mrrs_pkg::INIT_SLICE_T1;
                end
            end
            mrrs_pkg::OP_AL_CHK:
            begin
                tw_en   = (tmark_q == mrrs_pkg::MARK_FREE);
                tw_mark = mrrs_pkg::MARK_SLEEP;
                tw_lvl  = tlvl_q;
                tw_slc  = tslc_q;
            end
            mrrs_pkg::OP_RUN_WR:
            begin
                tw_en   = 1'b1;
                tw_addr = tid_reg;
                tw_mark = mrrs_pkg::MARK_RUN;
                tw_lvl  = newlv_reg;
                tw_slc  = newslc_reg;
            end
            mrrs_pkg::OP_SL_WR:
            begin
                tw_en   = 1'b1;
                tw_addr = tid_reg;
                tw_mark = mrrs_pkg::MARK_SLEEP;
                tw_lvl  = tlv_reg;
                tw_slc  = tsl_reg;
            end
            default:
            begin
                tw_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tw_en)
        begin
            mark_mem[tw_addr] <= tw_mark;
            lvl_mem[tw_addr]  <= tw_lvl;
            slc_mem[tw_addr]  <= tw_slc;
        end
        if (t_rd_en)
        begin
            tmark_q <= mark_mem[t_rd_addr];
            tlvl_q  <= lvl_mem[t_rd_addr];
            tslc_q  <= slc_mem[t_rd_addr];
        end
    end

    // control registers: counts, cursors, level selection, step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                cnt_reg[i] <= ((i == 0) || (i == NUM_LEVELS - 1)) ? CW'(1) : '0;
                cur_reg[i] <= '0;
            end
            cur_level_reg <= '0;
            pending_reg   <= 1'b1;
            idx_reg       <= '0;
            lv_reg        <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd.op == mrrs_pkg::OP_OUT);
            case (cmd.op)
                mrrs_pkg::OP_CLR:
                begin
                    idx_reg <= idx_last ? '0 : idx_reg + IW'(1);
                end
                mrrs_pkg::OP_LOAD:
                begin
                    idx_reg <= '0;
                end
                mrrs_pkg::OP_AL_CHK:
                begin
                    idx_reg <= idx_reg + IW'(1);
                end
                mrrs_pkg::OP_LV_CUR:
                begin
                    lv_reg <= cur_level_reg;
                end
                mrrs_pkg::OP_LV_TASK:
                begin
                    lv_reg  <= tlv_reg;
                    idx_reg <= '0;
                end
                mrrs_pkg::OP_LV_NEW:
                begin
                    lv_reg <= newlv_reg;
                end
                mrrs_pkg::OP_RM_CHK:
                begin
                    if (ldata_q == tid_reg)
                    begin
                        cnt_reg[lv_reg] <= n_new;
                        cur_reg[lv_reg] <= cur_rm;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                end
                mrrs_pkg::OP_SH_WR:
                begin
                    idx_reg <= idx_reg + IW'(1);
                end
                mrrs_pkg::OP_ADD:
                begin
                    if (cnt_rd < CW'(NUM_TASKS))
                    begin
                        cnt_reg[lv_reg] <= cnt_rd + CW'(1);
                    end
                end
                mrrs_pkg::OP_RUN_WR:
                begin
                    pending_reg <= 1'b1;
                end
                mrrs_pkg::OP_TK_ADV:
                begin
                    cur_reg[lv_reg] <= (tick_nxt >= IW'(cnt_rd)) ? '0 : TW'(tick_nxt);
                end
                mrrs_pkg::OP_PICK_INIT:
                begin
                    lv_reg <= '0;
                end
                mrrs_pkg::OP_PICK:
                begin
                    if (cnt_rd != '0)
                    begin
                        cur_level_reg <= lv_reg;
                        pending_reg   <= 1'b0;
                    end
                    else if (lv_reg == LW'(NUM_LEVELS - 1))
                    begin
                        pending_reg <= 1'b0;
                    end
                    else
                    begin
                        lv_reg <= lv_reg + LW'(1);
                    end
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    // transaction payload and result registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            mrrs_pkg::OP_LOAD:
            begin
                func_reg   <= mrrs_pkg::func_t'(func);
                tid_reg    <= TW'(task_id);
                oor_reg    <= (int'(task_id) >= NUM_TASKS);
                lvreq_reg  <= target_level;
                slc_in_reg <= slice_ticks;
                status_reg <= ((mrrs_pkg::func_t'(func) == mrrs_pkg::FN_SLEEP)
                              && (int'(task_id) >= NUM_TASKS))
                              ? mrrs_pkg::STS_NOT_RUN : mrrs_pkg::STS_DONE;
                res_reg    <= '0;
                sw_chk_reg <= 1'b0;
                reload_reg <= 1'b0;
            end
            mrrs_pkg::OP_AL_CHK:
            begin
                if (tmark_q == mrrs_pkg::MARK_FREE)
                begin
                    res_reg    <= idx_reg[TW-1:0];
                    status_reg <= mrrs_pkg::STS_DONE;
                end
                else if (idx_last)
                begin
                    res_reg    <= '0;
                    status_reg <= mrrs_pkg::STS_NO_FREE;
                end
            end
            mrrs_pkg::OP_RUN_EV:
            begin
                tlv_reg    <= tlvl_q;
                newlv_reg  <= lv_new;
                newslc_reg <= (slc_in_reg != 8'd0) ? slc_in_reg : tslc_q;
            end
            mrrs_pkg::OP_SL_EV:
            begin
                tlv_reg <= tlvl_q;
                tsl_reg <= tslc_q;
                if (tmark_q != mrrs_pkg::MARK_RUN)
                begin
                    status_reg <= mrrs_pkg::STS_NOT_RUN;
                end
            end
            mrrs_pkg::OP_BF_CAP:
            begin
                before_reg <= ldata_q;
            end
            mrrs_pkg::OP_SL_WR:
            begin
                sw_chk_reg <= (tid_reg == before_reg);
            end
            mrrs_pkg::OP_TK_ADV:
            begin
                reload_reg <= 1'b1;
                sw_chk_reg <= 1'b1;
            end
            mrrs_pkg::OP_OUT:
            begin
                status_out_reg <= status_reg;
                result_out_reg <= (func_reg == mrrs_pkg::FN_ALLOC) ? 6'(res_reg)
                                                                   : 6'(ldata_q);
                reload_out_reg <= tslc_q;
                timer_out_reg  <= reload_reg;
                sw_out_reg     <= sw_chk_reg && (ldata_q != before_reg);
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

    always_comb
    begin
        stat.func          = func_reg;
        stat.oor           = oor_reg;
        stat.t_free        = (tmark_q == mrrs_pkg::MARK_FREE);
        stat.t_run         = (tmark_q == mrrs_pkg::MARK_RUN);
        stat.lv_differs    = (tlvl_q != lv_new);
        stat.idx_ge_cnt    = (idx_reg >= IW'(cnt_rd));
        stat.idx_last      = idx_last;
        stat.match         = (ldata_q == tid_reg);
        stat.tid_is_before = (tid_reg == before_reg);
        stat.cnt_nz        = (cnt_rd != '0);
        stat.lv_last       = (lv_reg == LW'(NUM_LEVELS - 1));
        stat.pending       = pending_reg;
    end

    assign done          = done_reg;
    assign status        = status_out_reg;
    assign result_task   = result_out_reg;
    assign reload_ticks  = reload_out_reg;
    assign reload_timer  = timer_out_reg;
    assign switch_needed = sw_out_reg;

endmodule

[hw/rtl/multilevel_round_robin_scheduler.sv]
// Top level of the multilevel round-robin scheduler: sequencer plus datapath.
// Depends on mrrs_pkg, mrrs_ctrl, mrrs_dp and the assertion macro header.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------------
//  command   | start / busy       | func, task_id, target_level, slice_ticks
//  result    | done (1-cycle)     | status, result_task, reload_ticks,
//            |                    | reload_timer, switch_needed
//
// One command at a time; a command is taken when start is high and busy low.
// Busy time per command depends on its path: a run may add the task to a list, a tick
// advances the cursor, an ignored sleep leaves the lists alone and allocate scans slot by slot.
// A task leaving a level adds a search of its list and a shift of the entries behind it; choosing
// a new level looks at the levels in turn. done pulses in the first cycle busy is low.
// After reset a clearing pass over every task slot loads the task table with busy high.
// The receiver cannot stall; every list walk runs on the one list read port.
`include "multilevel_round_robin_scheduler_assert.svh"

module multilevel_round_robin_scheduler #(
    parameter int NUM_TASKS  = mrrs_pkg::DEF_NUM_TASKS,
    parameter int NUM_LEVELS = mrrs_pkg::DEF_NUM_LEVELS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        func,
    input  logic [5:0]        task_id,
    input  logic signed [3:0] target_level,
    input  logic [7:0]        slice_ticks,
    output logic              done,
    output logic [1:0]        status,
    output logic [5:0]        result_task,
    output logic [7:0]        reload_ticks,
    output logic              reload_timer,
    output logic              switch_needed
);

    mrrs_pkg::dp_cmd_t  cmd;
    mrrs_pkg::dp_stat_t stat;

    // sequencer: one state per datapath step
    mrrs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    // task table, level lists and result registers
    mrrs_dp #(
        .NUM_TASKS  (NUM_TASKS),
        .NUM_LEVELS (NUM_LEVELS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .func          (func),
        .task_id       (task_id),
        .target_level  (target_level),
        .slice_ticks   (slice_ticks),
        .done          (done),
        .status        (status),
        .result_task   (result_task),
        .reload_ticks  (reload_ticks),
        .reload_timer  (reload_timer),
        .switch_needed (switch_needed)
    );

    // an accepted transaction keeps the block busy until its result
    `MRRS_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // the result strobe fires only once the sequencer is back at rest
    `MRRS_ASSERT_HOLD(a_done_idle, clk, rst_n, done, !busy)
    `MRRS_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    // failed allocate reports task zero
    `MRRS_ASSERT_HOLD(a_nofree_zero, clk, rst_n,
        done && (status == 2'(mrrs_pkg::STS_NO_FREE)), result_task == 6'd0)

endmodule

[bench/multilevel_round_robin_scheduler_test.sv]
// Self-checking testbench for the multilevel round-robin scheduler.
// Depends on mrrs_pkg and the multilevel_round_robin_scheduler RTL.
// Commands are driven on the start/busy handshake and results are checked against a local model.
module multilevel_round_robin_scheduler_test;

    localparam int NT = 64;
    localparam int NL = 8;
    localparam int WATCHDOG_LIMIT = 20000;

    // Command fields and the expected result for one transaction.
    typedef struct {
        mrrs_pkg::func_t fn;
        logic [5:0]      tid;
        logic [3:0]      lvl;
        logic [7:0]      slc;
    } cmd_t;

    typedef struct {
        mrrs_pkg::status_t sts;
        logic [5:0]        task_no;
        logic [7:0]        ticks;
        logic              reload;
        logic              sw;
    } sched_result_t;

    // Directed table: a row may carry a typed-in result (has_exp = 1).
    typedef struct {
        cmd_t          cmd;
        bit            has_exp;
        sched_result_t exp;
    } dir_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        func = '0;
    logic [5:0]        task_id = '0;
    logic signed [3:0] target_level = '0;
    logic [7:0]        slice_ticks = '0;
    logic              done;
    logic [1:0]        status;
    logic [5:0]        result_task;
    logic [7:0]        reload_ticks;
    logic              reload_timer;
    logic              switch_needed;

    multilevel_round_robin_scheduler i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .task_id      (task_id),
        .target_level (target_level),
        .slice_ticks  (slice_ticks),
        .done         (done),
        .status       (status),
        .result_task  (result_task),
        .reload_ticks (reload_ticks),
        .reload_timer (reload_timer),
        .switch_needed(switch_needed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Scheduler model state (mirrors the block's bookkeeping)
    // ---------------------------------------------------------------
    mrrs_pkg::mark_t mark_q   [NT];
    logic [2:0]      level_of [NT];
    logic [7:0]      slice_of [NT];
    logic [5:0]      lists    [NL][NT];
    int              lcount   [NL];
    int              lcursor  [NL];
    logic [2:0]      cur_lvl;
    bit              lvl_pending;

    sched_result_t pending_results[$];
    int            err_count;
    int            n_sent;
    int            n_checked;
    int            idle_cycles;
    int            sender_idle_pct;
    int            tick_switches;

    task automatic sched_reset();
        for (int t = 0; t < NT; t++)
        begin
            mark_q[t] = mrrs_pkg::MARK_FREE;
            level_of[t] = '0;
            slice_of[t] = '0;
        end
        for (int l = 0; l < NL; l++)
        begin
            lcount[l] = 0;
            lcursor[l] = 0;
            for (int t = 0; t < NT; t++)
                lists[l][t] = '0;
        end
        mark_q[0] = mrrs_pkg::MARK_RUN;
        slice_of[0] = mrrs_pkg::INIT_SLICE_T0;
        lists[0][0] = 6'd0;
        lcount[0] = 1;
        mark_q[1] = mrrs_pkg::MARK_RUN;
        level_of[1] = 3'(NL - 1);
        slice_of[1] = mrrs_pkg::INIT_SLICE_T1;
        lists[NL-1][0] = 6'd1;
        lcount[NL-1] = 1;
        cur_lvl = '0;
        lvl_pending = 1'b1;
    endtask

    function automatic logic [5:0] running_task();
        return lists[cur_lvl][lcursor[cur_lvl] % NT];
    endfunction

    task automatic enqueue_task(int t);
        int l;
        l = level_of[t];
        if (lcount[l] < NT)
        begin
            lists[l][lcount[l]] = 6'(t);
            lcount[l]++;
        end
        mark_q[t] = mrrs_pkg::MARK_RUN;
    endtask

    task automatic dequeue_task(int t);
        int l;
        int i;
        l = level_of[t];
        for (i = 0; i < lcount[l]; i++)
            if (lists[l][i] == 6'(t))
                break;
        mark_q[t] = mrrs_pkg::MARK_SLEEP;
        if (i < lcount[l])
        begin
            lcount[l]--;
            if (i < lcursor[l])
                lcursor[l]--;
            if (lcursor[l] >= lcount[l])
                lcursor[l] = 0;
            for (; i < lcount[l]; i++)
                lists[l][i] = lists[l][i+1];
        end
    endtask

    task automatic choose_level();
        for (int l = 0; l < NL; l++)
            if (lcount[l] > 0)
            begin
                cur_lvl = 3'(l);
                break;
            end
        lvl_pending = 1'b0;
    endtask

    // Applies one command to the model and returns the result it must produce.
    task automatic sched_predict(input cmd_t c, output sched_result_t r);
        logic [5:0] prev;
        int         lv;
        int         nxt;
        bit         report_cur;
        r = '{mrrs_pkg::STS_DONE, 6'd0, 8'd0, 1'b0, 1'b0};
        report_cur = 1'b1;
        case (c.fn)
            mrrs_pkg::FN_ALLOC:
            begin
                report_cur = 1'b0;
                r.sts = mrrs_pkg::STS_NO_FREE;
                for (int t = 0; t < NT; t++)
                    if (mark_q[t] == mrrs_pkg::MARK_FREE)
                    begin
                        mark_q[t] = mrrs_pkg::MARK_SLEEP;
                        r.task_no = 6'(t);
                        r.sts = mrrs_pkg::STS_DONE;
                        break;
                    end
            end
            mrrs_pkg::FN_RUN:
            begin
                lv = c.lvl[3] ? int'(level_of[c.tid]) : int'(c.lvl);
                if (lv >= NL)
                    lv = NL - 1;
                if (c.slc != 0)
                    slice_of[c.tid] = c.slc;
                if (mark_q[c.tid] == mrrs_pkg::MARK_RUN && int'(level_of[c.tid]) != lv)
                    dequeue_task(c.tid);
                if (mark_q[c.tid] != mrrs_pkg::MARK_RUN)
                begin
                    level_of[c.tid] = 3'(lv);
                    enqueue_task(c.tid);
                end
                lvl_pending = 1'b1;
            end
            mrrs_pkg::FN_SLEEP:
            begin
                if (mark_q[c.tid] != mrrs_pkg::MARK_RUN)
                    r.sts = mrrs_pkg::STS_NOT_RUN;
                else
                begin
                    prev = running_task();
                    dequeue_task(c.tid);
                    if (c.tid == prev)
                    begin
                        choose_level();
                        r.sw = (running_task() != prev);
                    end
                end
            end
            default:
            begin
                prev = running_task();
                nxt = lcursor[cur_lvl] + 1;
                if (nxt >= lcount[cur_lvl])
                    nxt = 0;
                lcursor[cur_lvl] = nxt;
                if (lvl_pending)
                    choose_level();
                r.reload = 1'b1;
                r.sw = (running_task() != prev);
            end
        endcase
        if (report_cur)
            r.task_no = running_task();
        r.ticks = slice_of[running_task()];
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 n_checked, what, got, want);
    endtask

    // ---------------------------------------------------------------
    // Result monitor: done is a one-cycle strobe, sampled on the edge
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        sched_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                err_count++;
                $display("unexpected result with nothing pending");
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.sts)
                    report_mismatch("status", status, want.sts);
                if (result_task !== want.task_no)
                    report_mismatch("result_task", result_task, want.task_no);
                if (reload_ticks !== want.ticks)
                    report_mismatch("reload_ticks", reload_ticks, want.ticks);
                if (reload_timer !== want.reload)
                    report_mismatch("reload_timer", reload_timer, want.reload);
                if (switch_needed !== want.sw)
                    report_mismatch("switch_needed", switch_needed, want.sw);
                if (want.reload && want.sw)
                    tick_switches++;
            end
            n_checked++;
        end
    end

    // Watchdog: cycles with no transaction on either side.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Sends one command; a typed-in expectation overrides the model's answer
    // but the model still advances so the state stays in step.
    // start stays high after the accepting edge unless the sender idles.
    task automatic send_cmd(input cmd_t c, input bit has_exp, input sched_result_t fixed);
        sched_result_t r;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct)
                @(posedge clk);
        end
        start <= 1'b1;
        func <= c.fn;
        task_id <= c.tid;
        target_level <= c.lvl;
        slice_ticks <= c.slc;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sched_predict(c, r);
        pending_results.push_back(has_exp ? fixed : r);
        n_sent++;
    endtask

    // Random command biased toward tasks that exist, so lists get long.
    function automatic cmd_t random_cmd();
        cmd_t c;
        int   pick;
        pick = $urandom_range(99);
        c.fn = (pick < 20) ? mrrs_pkg::FN_ALLOC : (pick < 55) ? mrrs_pkg::FN_RUN
             : (pick < 75) ? mrrs_pkg::FN_SLEEP : mrrs_pkg::FN_TICK;
        c.tid = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(15));
        c.lvl = 4'($urandom);
        c.slc = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom);
        return c;
    endfunction

    dir_row_t directed[$];

    function automatic dir_row_t row(mrrs_pkg::func_t f, int t, int l, int s, bit he,
                                     mrrs_pkg::status_t st, int rt, int rk, bit rl, bit sw);
        dir_row_t d;
        d.cmd = '{f, 6'(t), 4'(l), 8'(s)};
        d.has_exp = he;
        d.exp = '{st, 6'(rt), 8'(rk), rl, sw};
        return d;
    endfunction

    initial
    begin
        sched_result_t none;
        none = '{mrrs_pkg::STS_DONE, 6'd0, 8'd0, 1'b0, 1'b0};
        err_count = 0;
        n_sent = 0;
        n_checked = 0;
        idle_cycles = 0;
        sender_idle_pct = 0;
        tick_switches = 0;
        sched_reset();

        // After reset: tick keeps task 0 at level 0, reload with its slice 2.
        directed.push_back(row(mrrs_pkg::FN_TICK,  0,  0,   0, 1,
                               mrrs_pkg::STS_DONE, 0, 2, 1, 0));
        // Sleep of a free task is ignored, at a low and at the highest task number.
        directed.push_back(row(mrrs_pkg::FN_SLEEP, 5,  0,   0, 1,
                               mrrs_pkg::STS_NOT_RUN, 0, 2, 0, 0));
        directed.push_back(row(mrrs_pkg::FN_SLEEP, 63, 0,   0, 1,
                               mrrs_pkg::STS_NOT_RUN, 0, 2, 0, 0));
        // Allocate gives the lowest free slot.
        directed.push_back(row(mrrs_pkg::FN_ALLOC, 0,  0,   0, 1,
                               mrrs_pkg::STS_DONE, 2, 2, 0, 0));
        directed.push_back(row(mrrs_pkg::FN_RUN,   2,  0, 255, 0,
                               mrrs_pkg::STS_DONE, 0, 0, 0, 0));
        directed.push_back(row(mrrs_pkg::FN_TICK,  0,  0,   0, 0,
                               mrrs_pkg::STS_DONE, 0, 0, 0, 0));
        // Same-level rerun with no slice keeps the old slice; keep-level and top levels.
        directed.push_back(row(mrrs_pkg::FN_RUN,   2, -1,   0, 0,
                               mrrs_pkg::STS_DONE, 0, 0, 0, 0));
        directed.push_back(row(mrrs_pkg::FN_RUN,   3,  7,   1, 0,
                               mrrs_pkg::STS_DONE, 0, 0, 0, 0));
        directed.push_back(row(mrrs_pkg::FN_RUN,   4, -8,   9, 0,
                               mrrs_pkg::STS_DONE, 0, 0, 0, 0));
        directed.push_back(row(mrrs_pkg::FN_RUN,  63,  5,  77, 0,
                               mrrs_pkg::STS_DONE, 0, 0, 0, 0));
        directed.push_back(row(mrrs_pkg::FN_RUN,   2,  3,   0, 0,
                               mrrs_pkg::STS_DONE, 0, 0, 0, 0));
        // Sleep tasks in turn, with ticks in between, until every level is empty.
        directed.push_back(row(mrrs_pkg::FN_SLEEP, 0,  0,   0, 0,
                               mrrs_pkg::STS_DONE, 0, 0, 0, 0));
        directed.push_back(row(mrrs_pkg::FN_TICK,  0,  0,   0, 0,
                               mrrs_pkg::STS_DONE, 0, 0, 0, 0));
        directed.push_back(row(mrrs_pkg::FN_SLEEP, 2,  0,   0, 0,
                               mrrs_pkg::STS_DONE, 0, 0, 0, 0));
        directed.push_back(row(mrrs_pkg::FN_TICK,  0,  0,   0, 0,
                               mrrs_pkg::STS_DONE, 0, 0, 0, 0));
        directed.push_back(row(mrrs_pkg::FN_SLEEP, 63, 0,   0, 0,
                               mrrs_pkg::STS_DONE, 0, 0, 0, 0));
        directed.push_back(row(mrrs_pkg::FN_TICK,  0,  0,   0, 0,
                               mrrs_pkg::STS_DONE, 0, 0, 0, 0));
        directed.push_back(row(mrrs_pkg::FN_SLEEP, 1,  0,   0, 0,
                               mrrs_pkg::STS_DONE, 0, 0, 0, 0));
        directed.push_back(row(mrrs_pkg::FN_SLEEP, 3,  0,   0, 0,
                               mrrs_pkg::STS_DONE, 0, 0, 0, 0));
        directed.push_back(row(mrrs_pkg::FN_SLEEP, 4,  0,   0, 0,
                               mrrs_pkg::STS_DONE, 0, 0, 0, 0));
        // All levels empty: tick on an empty level.
        directed.push_back(row(mrrs_pkg::FN_TICK,  0,  0,   0, 0,
                               mrrs_pkg::STS_DONE, 0, 0, 0, 0));
        directed.push_back(row(mrrs_pkg::FN_RUN,   0,  0,   0, 0,
                               mrrs_pkg::STS_DONE, 0, 0, 0, 0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_cmd(directed[i].cmd, directed[i].has_exp, directed[i].exp);

        // Random phases with varied sender idling.
        for (int ph = 0; ph < 4; ph++)
        begin
            sender_idle_pct = (ph == 1) ? 75 : (ph == 2) ? 19 : 0;
            repeat (120)
                send_cmd(random_cmd(), 1'b0, none);
            // Drain fully before continuing.
            start <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
        end
        // Exhaust allocation to reach the no-free-slot error.
        sender_idle_pct = 0;
        repeat (66)
        begin
            cmd_t c;
            c = '{mrrs_pkg::FN_ALLOC, 6'd0, 4'd0, 8'd0};
            send_cmd(c, 1'b0, none);
        end

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("sent %0d commands, checked %0d results, %0d tick switches",
                 n_sent, n_checked, tick_switches);
        if (err_count == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
